// ===== design/vad_speech_region_segmenter_core_defines.svh =====
// assertion macros shared by the speech region segmenter rtl
// used by files that include this header, expects i_clk and i_rst_n in scope
`ifndef VAD_SPEECH_REGION_SEGMENTER_CORE_DEFINES_SVH
`define VAD_SPEECH_REGION_SEGMENTER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VSRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define VSRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vsrs_pkg.sv =====
// types and constants for the speech region segmenter
// no dependencies
`default_nettype none

package vsrs_pkg;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_FRAME  = 2'd0,
        OP_FINISH = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // register indexes
    localparam t_cfg_idx REG_FRAME_LENGTH = 3'd0;
    localparam t_cfg_idx REG_THRESHOLD    = 3'd1;
    localparam t_cfg_idx REG_MIN_SILENCE  = 3'd2;
    localparam t_cfg_idx REG_MIN_SPEECH   = 3'd3;
    localparam t_cfg_idx REG_PADDING      = 3'd4;

    // register reset values
    localparam logic [9:0]  RST_FRAME_LENGTH = 10'd32;
    localparam logic [15:0] RST_THRESHOLD    = 16'd32768;
    localparam logic [15:0] RST_MIN_SILENCE  = 16'd100;
    localparam logic [15:0] RST_MIN_SPEECH   = 16'd250;
    localparam logic [15:0] RST_PADDING      = 16'd30;

    // one result transaction
    typedef struct packed {
        logic        region_valid;
        logic [31:0] region_start_ms;
        logic [31:0] region_end_ms;
        logic        final_region;
    } t_result;

endpackage

`default_nettype wire

// ===== design/vsrs_if.sv =====
// valid/ready channel interfaces for the speech region segmenter
// depends on vsrs_pkg
`default_nettype none

interface vsrs_in_if
    import vsrs_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] probability;
    logic [31:0] audio_duration_ms;

    modport source (output valid, output operation, output probability,
                    output audio_duration_ms, input ready);
    modport sink   (input valid, input operation, input probability,
                    input audio_duration_ms, output ready);
endinterface

interface vsrs_out_if
    import vsrs_pkg::*;
;
    logic        valid;
    logic        ready;
    logic        region_valid;
    logic [31:0] region_start_ms;
    logic [31:0] region_end_ms;
    logic        final_region;

    modport source (output valid, output region_valid, output region_start_ms,
                    output region_end_ms, output final_region, input ready);
    modport sink   (input valid, input region_valid, input region_start_ms,
                    input region_end_ms, input final_region, output ready);
endinterface

interface vsrs_cfg_if
    import vsrs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/vad_speech_region_segmenter_core.sv =====
// speech region segmenter: frame probabilities in, padded speech regions out
// depends on vsrs_pkg, vsrs_if and vad_speech_region_segmenter_core_defines.svh
//
// usage
//   i_in carries one transaction per frame (operation frame, with probability),
//   a finish (with audio_duration_ms) or a clear. o_out carries result
//   transactions: a closed region when a new one replaces the held region, and
//   on finish one last transaction with final_region set. i_cfg writes the
//   five registers by index; the user must write them only while the block
//   is idle, which the block itself does not enforce; i_cfg is always ready.
//   an accepted transaction is captured in the input register; from there it
//   is evaluated and pushes 0..2 results into an 8-entry output queue, whose
//   head drives o_out. throughput: one transaction per cycle while i_in.ready
//   is high; the segmentation logic is a single pass of adds and compares
//   between the input register and the queue.
//   i_in.ready drops while the queue count, plus two for an item still held
//   in the input register, is above six, so the queue can always absorb the
//   two results of an in-flight item.
//   a stalled receiver therefore never loses results; it backs up into i_in.
//   reset (synchronous, active low) loads the register defaults, clears all
//   segmentation state and empties the queue.
`default_nettype none
`include "vad_speech_region_segmenter_core_defines.svh"

module vad_speech_region_segmenter_core
    import vsrs_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vsrs_cfg_if.sink    i_cfg,
    vsrs_in_if.sink     i_in,
    vsrs_out_if.source  o_out
);

    localparam int W          = TIME_WIDTH;
    localparam int XW         = (W > 32) ? W : 32;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam logic [W-1:0] TIME_MAX = '1;

    // saturating time add
    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a,
                                             input logic [W-1:0] b);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[W] ? TIME_MAX : s[W-1:0];
    endfunction

    // time to 32-bit output field, saturating
    function automatic logic [31:0] out_time(input logic [W-1:0] v);
        logic [XW-1:0] t;
        t = XW'(v);
        return (t > XW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    // configuration registers
    logic [9:0]  r_frame_len;
    logic [15:0] r_threshold;
    logic [15:0] r_min_silence;
    logic [15:0] r_min_speech;
    logic [15:0] r_padding;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_op;
    logic [15:0] r_prob;
    logic [31:0] r_dur;

    // segmentation state
    logic [W-1:0] r_frame_time,   n_frame_time;
    logic         r_speech_active, n_speech_active;
    logic [W-1:0] r_speech_start, n_speech_start;
    logic         r_silence_active, n_silence_active;
    logic [W-1:0] r_silence_start, n_silence_start;
    logic         r_pend_valid,   n_pend_valid;
    logic [W-1:0] r_pend_start,   n_pend_start;
    logic [W-1:0] r_pend_end,     n_pend_end;

    // output queue
    t_result            r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len   <= RST_FRAME_LENGTH;
            r_threshold   <= RST_THRESHOLD;
            r_min_silence <= RST_MIN_SILENCE;
            r_min_speech  <= RST_MIN_SPEECH;
            r_padding     <= RST_PADDING;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FRAME_LENGTH: r_frame_len   <= i_cfg.data[9:0];
                REG_THRESHOLD:    r_threshold   <= i_cfg.data;
                REG_MIN_SILENCE:  r_min_silence <= i_cfg.data;
                REG_MIN_SPEECH:   r_min_speech  <= i_cfg.data;
                REG_PADDING:      r_padding     <= i_cfg.data;
                default: ;    // indexes past the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register and flow control
    // ------------------------------------------------------------------
    logic             in_fire;
    logic [CNT_W-1:0] reserve;

    // an item in the input register may still push two results this cycle
    assign reserve    = r_in_valid ? CNT_W'(2) : '0;
    assign i_in.ready = (r_count + reserve) <= CNT_W'(FIFO_DEPTH - 2);
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= i_in.operation;
            r_prob <= i_in.probability;
            r_dur  <= i_in.audio_duration_ms;
        end
    end

    // ------------------------------------------------------------------
    // segmentation datapath
    // ------------------------------------------------------------------
    logic          is_frame;
    logic          is_finish;
    logic          is_clear;
    logic          above;
    logic [XW-1:0] dur_x;
    logic [W-1:0]  dur_c;
    logic [W-1:0]  sil_eff;
    logic          sil_done;
    logic          do_close;
    logic [W-1:0]  close_end;
    logic          keep;
    logic [W-1:0]  pad_w;
    logic [W-1:0]  ps;
    logic [W-1:0]  pe;
    logic          merge;
    logic          emit_v;
    logic          post_v;
    logic [W-1:0]  post_s;
    logic [W-1:0]  post_e;
    logic [W-1:0]  fin_end;
    t_result       res_emit;
    t_result       res_final;

    assign is_frame  = r_in_valid && (r_op == OP_FRAME);
    assign is_finish = r_in_valid && (r_op == OP_FINISH);
    assign is_clear  = r_in_valid && (r_op == OP_CLEAR);
    assign above     = r_prob >= r_threshold;

    // finish duration clamped to the time range
    assign dur_x = XW'(r_dur);
    assign dur_c = (dur_x > XW'(TIME_MAX)) ? TIME_MAX : dur_x[W-1:0];

    // silence starts at this frame unless already open
    assign sil_eff  = r_silence_active ? r_silence_start : r_frame_time;
    assign sil_done = (r_frame_time - sil_eff) >= W'(r_min_silence);

    // the run closes at the silence start, or at the duration on finish
    assign close_end = is_finish ? dur_c : sil_eff;
    assign do_close  = r_speech_active &&
                       (is_finish || (is_frame && !above && sil_done));

    // a finish before speech start gives a negative length: run dropped
    assign keep  = (close_end >= r_speech_start) &&
                   ((close_end - r_speech_start) >= W'(r_min_speech));
    assign pad_w = W'(r_padding);
    assign ps    = (r_speech_start >= pad_w) ? (r_speech_start - pad_w) : '0;
    assign pe    = sat_add(close_end, pad_w);
    assign merge = r_pend_valid && (ps <= r_pend_end);

    // held region after the close
    always_comb begin
        post_v = r_pend_valid;
        post_s = r_pend_start;
        post_e = r_pend_end;
        if (do_close && keep) begin
            if (merge) begin
                if (pe > r_pend_end) begin
                    post_e = pe;
                end
            end else begin
                post_v = 1'b1;
                post_s = ps;
                post_e = pe;
            end
        end
    end

    // replaced held region is emitted
    assign emit_v = do_close && keep && !merge && r_pend_valid;

    assign res_emit.region_valid    = 1'b1;
    assign res_emit.region_start_ms = out_time(r_pend_start);
    assign res_emit.region_end_ms   = out_time(r_pend_end);
    assign res_emit.final_region    = 1'b0;

    // last region end clamped to the audio duration
    assign fin_end = (post_e < dur_c) ? post_e : dur_c;

    assign res_final.region_valid    = post_v;
    assign res_final.region_start_ms = post_v ? out_time(post_s) : '0;
    assign res_final.region_end_ms   = post_v ? out_time(fin_end) : '0;
    assign res_final.final_region    = 1'b1;

    // next state
    always_comb begin
        n_frame_time     = r_frame_time;
        n_speech_active  = r_speech_active;
        n_speech_start   = r_speech_start;
        n_silence_active = r_silence_active;
        n_silence_start  = r_silence_start;
        n_pend_valid     = r_pend_valid;
        n_pend_start     = r_pend_start;
        n_pend_end       = r_pend_end;
        if (is_frame) begin
            n_frame_time = sat_add(r_frame_time, W'(r_frame_len));
            if (above) begin
                if (!r_speech_active) begin
                    n_speech_active = 1'b1;
                    n_speech_start  = r_frame_time;
                end
                n_silence_active = 1'b0;
                n_silence_start  = '0;
            end else if (do_close) begin
                n_speech_active  = 1'b0;
                n_speech_start   = '0;
                n_silence_active = 1'b0;
                n_silence_start  = '0;
                n_pend_valid     = post_v;
                n_pend_start     = post_s;
                n_pend_end       = post_e;
            end else if (r_speech_active) begin
                n_silence_active = 1'b1;
                n_silence_start  = sil_eff;
            end
        end else if (is_finish || is_clear) begin
            n_frame_time     = '0;
            n_speech_active  = 1'b0;
            n_speech_start   = '0;
            n_silence_active = 1'b0;
            n_silence_start  = '0;
            n_pend_valid     = 1'b0;
            n_pend_start     = '0;
            n_pend_end       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time     <= '0;
            r_speech_active  <= 1'b0;
            r_speech_start   <= '0;
            r_silence_active <= 1'b0;
            r_silence_start  <= '0;
            r_pend_valid     <= 1'b0;
            r_pend_start     <= '0;
            r_pend_end       <= '0;
        end else begin
            r_frame_time     <= n_frame_time;
            r_speech_active  <= n_speech_active;
            r_speech_start   <= n_speech_start;
            r_silence_active <= n_silence_active;
            r_silence_start  <= n_silence_start;
            r_pend_valid     <= n_pend_valid;
            r_pend_start     <= n_pend_start;
            r_pend_end       <= n_pend_end;
        end
    end

    // ------------------------------------------------------------------
    // output queue
    // ------------------------------------------------------------------
    logic             push_a;
    logic             push_b;
    logic [1:0]       push_n;
    t_result          first_res;
    logic             pop;
    logic [PTR_W-1:0] wr_next;

    assign push_a    = emit_v;
    assign push_b    = is_finish;
    assign push_n    = {1'b0, push_a} + {1'b0, push_b};
    assign first_res = push_a ? res_emit : res_final;
    assign wr_next   = r_wr_ptr + PTR_W'(1);
    assign pop       = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= first_res;
        end
        if (push_n == 2'd2) begin
            r_fifo[wr_next] <= res_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    assign o_out.valid           = r_count != '0;
    assign o_out.region_valid    = r_fifo[r_rd_ptr].region_valid;
    assign o_out.region_start_ms = r_fifo[r_rd_ptr].region_start_ms;
    assign o_out.region_end_ms   = r_fifo[r_rd_ptr].region_end_ms;
    assign o_out.final_region    = r_fifo[r_rd_ptr].final_region;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `VSRS_ASSERT_NOW(a_queue_bound, push_n != 2'd0, r_count + CNT_W'(push_n) <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `VSRS_ASSERT_NOW(a_silence_in_speech, r_silence_active, r_speech_active, "silence open without speech")
    `VSRS_ASSERT_NOW(a_finish_pushes, is_finish, push_n != 2'd0, "finish produced no final result")
    `VSRS_ASSERT_NEXT(a_finish_clears, is_finish, !r_speech_active && !r_pend_valid && (r_frame_time == '0), "finish left state behind")

endmodule

`default_nettype wire
